### design/mmt_pkg.sv
package mmt_pkg;

    // default sizing of the table
    localparam int ENTRIES_DEFAULT    = 16;
    localparam int VALUE_BITS_DEFAULT = 16;

    // fixed widths of the channel fields
    localparam int ACTION_BITS = 2;
    localparam int INDEX_BITS  = 4;
    localparam int FIELD_BITS  = 16;

    // operation codes carried by an input item
    typedef enum logic [ACTION_BITS-1:0] {
        ACT_SET       = 2'd0,
        ACT_CLEAR     = 2'd1,
        ACT_RESCAN    = 2'd2,
        ACT_CLEAR_ALL = 2'd3
    } action_t;

    // outcome of the shared comparator pair
    typedef struct packed {
        logic lt;
        logic gt;
    } cmp_res_t;

endpackage

### design/mmt_req_if.sv
interface mmt_req_if;
    import mmt_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [ACTION_BITS-1:0] action;
    logic [INDEX_BITS-1:0]  entry_index;
    logic [FIELD_BITS-1:0]  entry_value;

    modport source (output valid, output action, output entry_index, output entry_value,
                    input ready);
    modport sink   (input valid, input action, input entry_index, input entry_value,
                    output ready);
endinterface

### design/mmt_rsp_if.sv
interface mmt_rsp_if;
    import mmt_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  was_limit;
    logic [FIELD_BITS-1:0] min_value;
    logic [FIELD_BITS-1:0] max_value;
    logic [INDEX_BITS-1:0] min_index;
    logic [INDEX_BITS-1:0] max_index;
    logic                  table_empty;

    modport source (output valid, output was_limit, output min_value, output max_value,
                    output min_index, output max_index, output table_empty, input ready);
    modport sink   (input valid, input was_limit, input min_value, input max_value,
                    input min_index, input max_index, input table_empty, output ready);
endinterface

### design/mmt_store.sv
module mmt_store #(
    parameter int ENTRIES    = mmt_pkg::ENTRIES_DEFAULT,
    parameter int VALUE_BITS = mmt_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        we,
    input  logic [$clog2(ENTRIES)-1:0]  waddr,
    input  logic [VALUE_BITS-1:0]       wdata,
    input  logic [$clog2(ENTRIES)-1:0]  raddr,
    output logic [VALUE_BITS-1:0]       rdata
);
    import mmt_pkg::*;

    logic [VALUE_BITS-1:0] mem [ENTRIES];
    logic [ENTRIES-1:0]    written_reg;
    logic [VALUE_BITS-1:0] rdata_reg;

    // entry array and registered read port, unwritten entries read as zero
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= written_reg[raddr] ? mem[raddr] : '0;
    end

    // per-entry written flags, cleared at once by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
        end
        else if (we)
        begin
            written_reg[waddr] <= 1'b1;
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/mmt_cmp.sv
module mmt_cmp #(
    parameter int VALUE_BITS = mmt_pkg::VALUE_BITS_DEFAULT
) (
    input  logic [VALUE_BITS-1:0] operand,
    input  logic [VALUE_BITS-1:0] lo_bound,
    input  logic [VALUE_BITS-1:0] hi_bound,
    output mmt_pkg::cmp_res_t     res
);
    import mmt_pkg::*;

    // strict tests against both bounds
    always_comb
    begin
        res.lt = (operand < lo_bound);
        res.gt = (operand > hi_bound);
    end

endmodule

### design/min_max_tracking_table_top.sv
// Min/max tracking table: ENTRIES unsigned values of VALUE_BITS bits, with the smallest and
// largest non-empty value and the index of the entry holding each. An entry is empty while it
// equals the empty marker register. Every item but a clear-all walks the whole table once
// through the single read port of the entry store, one entry a cycle, feeding one shared
// comparator pair. A set or clear with an index inside the table reads the old value and
// writes the entry before its walk, a rescan or an out-of-range index only walks, and a
// clear-all writes the marker into every entry, one write per entry, without a walk. One
// item is worked on at a time; the next item is taken only once the result is loaded into
// the output register. Reset needs no clearing pass: per-entry flags make unwritten entries
// read as zero. Write the marker only while no item is outstanding.
module min_max_tracking_table_top #(
    parameter int ENTRIES    = mmt_pkg::ENTRIES_DEFAULT,
    parameter int VALUE_BITS = mmt_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [mmt_pkg::FIELD_BITS-1:0]  cfg_wr_data,
    mmt_req_if.sink                         req,
    mmt_rsp_if.source                       rsp
);
    import mmt_pkg::*;

    localparam int SW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ_OLD,
        ST_CHECK,
        ST_SCAN,
        ST_CLEAR,
        ST_FINISH
    } state_t;

    state_t                state_reg;
    action_t               act_reg;
    logic [SW-1:0]         slot_reg;
    logic                  idx_ok_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [VALUE_BITS-1:0] marker_reg;
    logic [CW-1:0]         cnt_reg;
    logic                  chk_valid_reg;
    logic [SW-1:0]         chk_slot_reg;
    logic                  rescan_reg;
    logic                  lim_reg;
    logic                  any_reg;
    logic [VALUE_BITS-1:0] scan_min_reg;
    logic [VALUE_BITS-1:0] scan_max_reg;
    logic [SW-1:0]         scan_min_slot_reg;
    logic [SW-1:0]         scan_max_slot_reg;
    logic [VALUE_BITS-1:0] cur_min_reg;
    logic [VALUE_BITS-1:0] cur_max_reg;
    logic [SW-1:0]         min_slot_reg;
    logic [SW-1:0]         max_slot_reg;
    logic                  rsp_valid_reg;
    logic                  was_limit_reg;
    logic                  table_empty_reg;

    logic [VALUE_BITS-1:0] cur_min_next;
    logic [VALUE_BITS-1:0] cur_max_next;
    logic [SW-1:0]         min_slot_next;
    logic [SW-1:0]         max_slot_next;
    logic                  lim_next;

    logic                  mem_we;
    logic [SW-1:0]         mem_waddr;
    logic [VALUE_BITS-1:0] mem_wdata;
    logic [SW-1:0]         mem_raddr;
    logic [VALUE_BITS-1:0] mem_rdata;

    logic [VALUE_BITS-1:0] cmp_operand;
    logic [VALUE_BITS-1:0] cmp_lo;
    logic [VALUE_BITS-1:0] cmp_hi;
    cmp_res_t              cmp_res;

    logic                  out_free;
    logic                  fin_go;
    logic                  old_lim;
    logic                  rd_nonempty;

    // entry store
    mmt_store #(
        .ENTRIES    (ENTRIES),
        .VALUE_BITS (VALUE_BITS)
    ) u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // shared comparator pair
    mmt_cmp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_cmp (
        .operand  (cmp_operand),
        .lo_bound (cmp_lo),
        .hi_bound (cmp_hi),
        .res      (cmp_res)
    );

    // store port steering
    assign mem_we    = (state_reg == ST_CHECK) || (state_reg == ST_CLEAR);
    assign mem_waddr = (state_reg == ST_CLEAR) ? cnt_reg[SW-1:0] : slot_reg;
    assign mem_wdata = ((state_reg == ST_CHECK) && (act_reg == ACT_SET)) ? val_reg : marker_reg;
    assign mem_raddr = (state_reg == ST_SCAN) ? cnt_reg[SW-1:0] : slot_reg;

    // comparator operands: table walk, or the new value against the live limits
    assign cmp_operand = (state_reg == ST_FINISH) ? val_reg     : mem_rdata;
    assign cmp_lo      = (state_reg == ST_FINISH) ? cur_min_reg : scan_min_reg;
    assign cmp_hi      = (state_reg == ST_FINISH) ? cur_max_reg : scan_max_reg;

    assign rd_nonempty = (mem_rdata != marker_reg);
    assign old_lim     = rd_nonempty && ((mem_rdata == cur_min_reg) || (mem_rdata == cur_max_reg));
    assign out_free    = !rsp_valid_reg || rsp.ready;
    assign fin_go      = (state_reg == ST_FINISH) && out_free;

    // limit update at the end of an item
    always_comb
    begin
        cur_min_next  = cur_min_reg;
        cur_max_next  = cur_max_reg;
        min_slot_next = min_slot_reg;
        max_slot_next = max_slot_reg;
        lim_next      = 1'b0;
        priority if (act_reg == ACT_CLEAR_ALL)
        begin
            cur_min_next  = '1;
            cur_max_next  = '0;
            min_slot_next = '0;
            max_slot_next = '0;
        end
        else if (rescan_reg)
        begin
            cur_min_next  = scan_min_reg;
            cur_max_next  = scan_max_reg;
            min_slot_next = scan_min_slot_reg;
            max_slot_next = scan_max_slot_reg;
            if (act_reg == ACT_CLEAR)
            begin
                lim_next = 1'b1;
            end
            else if (act_reg == ACT_SET)
            begin
                lim_next = (val_reg != marker_reg) &&
                           ((scan_min_slot_reg == slot_reg) || (scan_max_slot_reg == slot_reg));
            end
        end
        else
        begin
            if ((act_reg == ACT_SET) && idx_ok_reg && (val_reg != marker_reg))
            begin
                if (cmp_res.gt)
                begin
                    cur_max_next  = val_reg;
                    max_slot_next = slot_reg;
                end
                if (cmp_res.lt)
                begin
                    cur_min_next  = val_reg;
                    min_slot_next = slot_reg;
                end
                lim_next = cmp_res.gt || cmp_res.lt;
            end
        end
    end

    // sequencer, limit state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            marker_reg    <= '0;
            cur_min_reg   <= '1;
            cur_max_reg   <= '0;
            min_slot_reg  <= '0;
            max_slot_reg  <= '0;
            rsp_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            chk_valid_reg <= 1'b0;
            rescan_reg    <= 1'b0;
            lim_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                marker_reg <= VALUE_BITS'(cfg_wr_data);
            end
            if (rsp_valid_reg && rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req.valid)
                    begin
                        act_reg           <= action_t'(req.action);
                        slot_reg          <= SW'(req.entry_index);
                        idx_ok_reg        <= (int'(req.entry_index) < ENTRIES);
                        val_reg           <= VALUE_BITS'(req.entry_value);
                        rescan_reg        <= (action_t'(req.action) == ACT_RESCAN);
                        lim_reg           <= 1'b0;
                        cnt_reg           <= '0;
                        chk_valid_reg     <= 1'b0;
                        any_reg           <= 1'b0;
                        scan_min_reg      <= '1;
                        scan_max_reg      <= '0;
                        scan_min_slot_reg <= '0;
                        scan_max_slot_reg <= '0;
                        if (action_t'(req.action) == ACT_CLEAR_ALL)
                        begin
                            state_reg <= ST_CLEAR;
                        end
                        else if ((action_t'(req.action) != ACT_RESCAN) &&
                                 (int'(req.entry_index) < ENTRIES))
                        begin
                            state_reg <= ST_READ_OLD;
                        end
                        else
                        begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end

                ST_READ_OLD:
                begin
                    state_reg <= ST_CHECK;
                end

                ST_CHECK:
                begin
                    // old value was a limit: rebuild after the write
                    rescan_reg <= old_lim;
                    state_reg  <= ST_SCAN;
                end

                ST_SCAN:
                begin
                    if (chk_valid_reg && rd_nonempty)
                    begin
                        any_reg <= 1'b1;
                        if (cmp_res.lt)
                        begin
                            scan_min_reg      <= mem_rdata;
                            scan_min_slot_reg <= chk_slot_reg;
                        end
                        if (cmp_res.gt)
                        begin
                            scan_max_reg      <= mem_rdata;
                            scan_max_slot_reg <= chk_slot_reg;
                        end
                    end
                    chk_slot_reg <= cnt_reg[SW-1:0];
                    if (cnt_reg == CW'(ENTRIES))
                    begin
                        chk_valid_reg <= 1'b0;
                        state_reg     <= ST_FINISH;
                    end
                    else
                    begin
                        chk_valid_reg <= 1'b1;
                        cnt_reg       <= cnt_reg + 1'b1;
                    end
                end

                ST_CLEAR:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CW'(ENTRIES - 1))
                    begin
                        state_reg <= ST_FINISH;
                    end
                end

                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        cur_min_reg     <= cur_min_next;
                        cur_max_reg     <= cur_max_next;
                        min_slot_reg    <= min_slot_next;
                        max_slot_reg    <= max_slot_next;
                        lim_reg         <= lim_next;
                        was_limit_reg   <= lim_next;
                        table_empty_reg <= !any_reg;
                        rsp_valid_reg   <= 1'b1;
                        state_reg       <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // channel outputs
    assign req.ready       = (state_reg == ST_IDLE);
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.was_limit   = was_limit_reg;
    assign rsp.min_value   = FIELD_BITS'(cur_min_reg);
    assign rsp.max_value   = FIELD_BITS'(cur_max_reg);
    assign rsp.min_index   = INDEX_BITS'(min_slot_reg);
    assign rsp.max_index   = INDEX_BITS'(max_slot_reg);
    assign rsp.table_empty = table_empty_reg;

`ifndef NO_ASSERTIONS
    // the store is not written while the table is walked
    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !mem_we)
        else $error("entry store written during table walk");

    // a walk that found nothing leaves the reset limits
    a_empty_walk: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FINISH) && (act_reg != ACT_CLEAR_ALL) && !any_reg)
        |-> ((scan_min_reg == '1) && (scan_max_reg == '0)))
        else $error("empty walk produced limits");

    // clear-all result reports an empty table and no limit hit
    a_clear_all_result: assert property (@(posedge clk) disable iff (!rst_n)
        (fin_go && (act_reg == ACT_CLEAR_ALL))
        |=> (rsp_valid_reg && table_empty_reg && !was_limit_reg && (cur_min_reg == '1)))
        else $error("clear-all result wrong");

    // a clear that hit a limit reports it
    a_clear_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (fin_go && (act_reg == ACT_CLEAR) && rescan_reg) |=> (was_limit_reg && lim_reg))
        else $error("clear of a limit entry not reported");
`endif

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import mmt_pkg::*;

    localparam int TABLE_SIZE     = ENTRIES_DEFAULT;
    // longest item latency plus some margin
    localparam int SETTLE_CYCLES  = TABLE_SIZE + 9;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        action_t               act;
        logic [INDEX_BITS-1:0] idx;
        logic [FIELD_BITS-1:0] val;
    } table_op_t;

    typedef struct packed {
        logic                  was_limit;
        logic [FIELD_BITS-1:0] min_value;
        logic [FIELD_BITS-1:0] max_value;
        logic [INDEX_BITS-1:0] min_index;
        logic [INDEX_BITS-1:0] max_index;
        logic                  table_empty;
    } table_status_t;

    // clock, reset and configuration
    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [FIELD_BITS-1:0] cfg_wr_data = '0;

    // request side drive
    logic                  req_valid  = 1'b0;
    action_t               req_action = ACT_SET;
    logic [INDEX_BITS-1:0] req_index  = '0;
    logic [FIELD_BITS-1:0] req_value  = '0;

    // response side drive
    logic                  rsp_ready  = 1'b0;

    // pacing state
    logic                  quiet       = 1'b0;
    logic                  hold_start  = 1'b0;
    int                    hold_left   = 0;
    int                    send_gap    = 0;
    int                    recv_gap    = 0;
    int                    idle_cycles = 0;
    int                    fails       = 0;

    table_op_t             op_queue[$];
    table_status_t         status_queue[$];

    // shadow copy of the table and its limits
    logic [FIELD_BITS-1:0] slot_vals[TABLE_SIZE];
    logic [FIELD_BITS-1:0] marker  = '0;
    logic [FIELD_BITS-1:0] lo_val  = '1;
    logic [FIELD_BITS-1:0] hi_val  = '0;
    logic [INDEX_BITS-1:0] lo_slot = '0;
    logic [INDEX_BITS-1:0] hi_slot = '0;

    mmt_req_if req_ch ();
    mmt_rsp_if rsp_ch ();

    assign req_ch.valid       = req_valid;
    assign req_ch.action      = req_action;
    assign req_ch.entry_index = req_index;
    assign req_ch.entry_value = req_value;
    assign rsp_ch.ready       = rsp_ready;

    min_max_tracking_table_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            slot_vals[i] = '0;
        end
    end

    // an entry is a limit when non-empty and equal to either bound
    function automatic logic holds_limit(logic [FIELD_BITS-1:0] v);
        return (v != marker) && (v == lo_val || v == hi_val);
    endfunction

    // full walk of the table, strict compares so the lowest index wins ties
    function automatic void rebuild_limits();
        lo_val  = '1;
        hi_val  = '0;
        lo_slot = '0;
        hi_slot = '0;
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            if (slot_vals[i] != marker)
            begin
                if (slot_vals[i] < lo_val)
                begin
                    lo_val  = slot_vals[i];
                    lo_slot = INDEX_BITS'(i);
                end
                if (slot_vals[i] > hi_val)
                begin
                    hi_val  = slot_vals[i];
                    hi_slot = INDEX_BITS'(i);
                end
            end
        end
    endfunction

    // applies one item to the shadow table and gives the status it should produce
    function automatic table_status_t apply_op(action_t act, logic [INDEX_BITS-1:0] idx,
                                               logic [FIELD_BITS-1:0] val);
        table_status_t st;
        logic          old_lim;
        st.was_limit = 1'b0;
        case (act)
            ACT_SET:
            begin
                old_lim        = holds_limit(slot_vals[idx]);
                slot_vals[idx] = val;
                if (old_lim)
                begin
                    rebuild_limits();
                    if (val != marker && (lo_slot == idx || hi_slot == idx))
                        st.was_limit = 1'b1;
                end
                else if (val != marker)
                begin
                    if (val > hi_val)
                    begin
                        hi_val       = val;
                        hi_slot      = idx;
                        st.was_limit = 1'b1;
                    end
                    if (val < lo_val)
                    begin
                        lo_val       = val;
                        lo_slot      = idx;
                        st.was_limit = 1'b1;
                    end
                end
            end
            ACT_CLEAR:
            begin
                old_lim        = holds_limit(slot_vals[idx]);
                slot_vals[idx] = marker;
                if (old_lim)
                begin
                    rebuild_limits();
                    st.was_limit = 1'b1;
                end
            end
            ACT_RESCAN:
            begin
                rebuild_limits();
            end
            default:
            begin
                for (int i = 0; i < TABLE_SIZE; i++)
                begin
                    slot_vals[i] = marker;
                end
                lo_val  = '1;
                hi_val  = '0;
                lo_slot = '0;
                hi_slot = '0;
            end
        endcase
        st.table_empty = 1'b1;
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            if (slot_vals[i] != marker)
                st.table_empty = 1'b0;
        end
        st.min_value = lo_val;
        st.max_value = hi_val;
        st.min_index = lo_slot;
        st.max_index = hi_slot;
        return st;
    endfunction

    // field by field compare against the oldest expected status
    function automatic void check_status(table_status_t got);
        table_status_t want;
        if (status_queue.size() == 0)
        begin
            $error("unexpected result item: no status pending");
            fails++;
            return;
        end
        want = status_queue.pop_front();
        if (got.was_limit !== want.was_limit)
        begin
            $error("was_limit: expected %0h, actual %0h", want.was_limit, got.was_limit);
            fails++;
        end
        if (got.min_value !== want.min_value)
        begin
            $error("min_value: expected %0h, actual %0h", want.min_value, got.min_value);
            fails++;
        end
        if (got.max_value !== want.max_value)
        begin
            $error("max_value: expected %0h, actual %0h", want.max_value, got.max_value);
            fails++;
        end
        if (got.min_index !== want.min_index)
        begin
            $error("min_index: expected %0h, actual %0h", want.min_index, got.min_index);
            fails++;
        end
        if (got.max_index !== want.max_index)
        begin
            $error("max_index: expected %0h, actual %0h", want.max_index, got.max_index);
            fails++;
        end
        if (got.table_empty !== want.table_empty)
        begin
            $error("table_empty: expected %0h, actual %0h", want.table_empty, got.table_empty);
            fails++;
        end
    endfunction

    // driver: predicts on acceptance, then offers the next pending item
    always @(posedge clk)
    begin : driver
        table_op_t nxt;
        if (rst_n)
        begin
            if (req_valid && req_ch.ready)
                status_queue.push_back(apply_op(req_action, req_index, req_value));
            if (!req_valid || req_ch.ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap  <= send_gap - 1;
                    req_valid <= 1'b0;
                end
                else if (op_queue.size() != 0 && !quiet && $urandom_range(0, 7) == 0)
                begin
                    send_gap  <= $urandom_range(0, 11);
                    req_valid <= 1'b0;
                end
                else if (op_queue.size() != 0)
                begin
                    nxt        = op_queue.pop_front();
                    req_action <= nxt.act;
                    req_index  <= nxt.idx;
                    req_value  <= nxt.val;
                    req_valid  <= 1'b1;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks accepted results and paces ready
    always @(posedge clk)
    begin : monitor
        table_status_t got;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ready)
            begin
                got.was_limit   = rsp_ch.was_limit;
                got.min_value   = rsp_ch.min_value;
                got.max_value   = rsp_ch.max_value;
                got.min_index   = rsp_ch.min_index;
                got.max_index   = rsp_ch.max_index;
                got.table_empty = rsp_ch.table_empty;
                check_status(got);
            end
            if (hold_left != 0)
            begin
                rsp_ready <= 1'b0;
            end
            else if (quiet)
            begin
                rsp_ready <= 1'b1;
            end
            else if (recv_gap != 0)
            begin
                recv_gap  <= recv_gap - 1;
                rsp_ready <= 1'b0;
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                recv_gap  <= $urandom_range(0, 11);
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= 1'b1;
            end
        end
    end

    // long receiver hold-off so the block backs up into its input
    always @(posedge clk)
    begin
        if (hold_start)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // watchdog on cycles with no item moving on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ch.ready) || (rsp_ch.valid && rsp_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic add_op(action_t act, int idx, int val);
        table_op_t op;
        op.act = act;
        op.idx = idx[INDEX_BITS-1:0];
        op.val = val[FIELD_BITS-1:0];
        op_queue.push_back(op);
    endtask

    // random items biased towards ties, extremes and the marker
    task automatic add_random_ops(int count);
        int                    pick;
        logic [FIELD_BITS-1:0] v;
        action_t               act;
        for (int n = 0; n < count; n++)
        begin
            case ($urandom_range(0, 7))
                0:       v = marker;
                1:       v = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                2, 3:    v = FIELD_BITS'($urandom_range(0, 15));
                default: v = FIELD_BITS'($urandom());
            endcase
            pick = $urandom_range(0, 99);
            if (pick < 55)
                act = ACT_SET;
            else if (pick < 85)
                act = ACT_CLEAR;
            else if (pick < 96)
                act = ACT_RESCAN;
            else
                act = ACT_CLEAR_ALL;
            add_op(act, int'($urandom_range(0, TABLE_SIZE - 1)), int'(v));
        end
    endtask

    task automatic wait_drained();
        while (op_queue.size() != 0 || req_valid || status_queue.size() != 0)
            @(posedge clk);
    endtask

    // marker change only once the block has gone quiet
    task automatic write_marker(logic [FIELD_BITS-1:0] v);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        marker       = v;
        cfg_wr_en   <= 1'b0;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed part with the reset marker of zero
        add_op(ACT_RESCAN, 0, 16'h0000);
        add_op(ACT_CLEAR_ALL, 0, 16'h0000);
        add_op(ACT_CLEAR, 3, 16'h0000);
        add_op(ACT_SET, 0, 16'hFFFF);
        add_op(ACT_SET, 15, 16'h0001);
        add_op(ACT_SET, 7, 16'hFFFF);
        add_op(ACT_SET, 8, 16'h8000);
        add_op(ACT_SET, 0, 16'h0002);
        add_op(ACT_RESCAN, 0, 16'h0000);
        add_op(ACT_CLEAR, 8, 16'h0000);
        add_op(ACT_CLEAR, 15, 16'h0000);
        add_op(ACT_SET, 7, 16'h0000);
        add_op(ACT_SET, 3, 16'h0000);
        add_op(ACT_SET, 4, 16'h0002);
        add_op(ACT_SET, 9, 16'hFFFE);
        add_op(ACT_SET, 10, 16'h0001);
        add_op(ACT_CLEAR, 10, 16'h0000);
        add_op(ACT_CLEAR_ALL, 0, 16'h0000);
        add_op(ACT_SET, 15, 16'hABCD);
        add_op(ACT_CLEAR, 15, 16'h0000);
        add_random_ops(120);

        // all-ones marker: zero becomes a real value
        write_marker(16'hFFFF);
        add_op(ACT_RESCAN, 0, 16'h0000);
        add_op(ACT_SET, 1, 16'h0000);
        add_op(ACT_SET, 2, 16'hFFFF);
        add_op(ACT_SET, 14, 16'hFFFE);
        add_random_ops(140);
        while (op_queue.size() > 100)
            @(posedge clk);
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;

        write_marker(FIELD_BITS'($urandom_range(1, 16'hFFFE)));
        add_random_ops(140);

        // marker inside the small value pool
        write_marker(16'h0005);
        add_random_ops(140);

        // closing stretch without idling
        write_marker(16'h0000);
        quiet = 1'b1;
        add_random_ops(140);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fails == 0 && status_queue.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### sim.f
design/mmt_pkg.sv
design/mmt_req_if.sv
design/mmt_rsp_if.sv
design/mmt_store.sv
design/mmt_cmp.sv
design/min_max_tracking_table_top.sv
tb/testbench.sv
